[sv/ecc_pkg.sv]
`timescale 1ns / 1ps

package ecc_pkg;

  localparam int FLOORS = 16;
  localparam int SLOTS  = 8;

  localparam int FLOOR_W = 5;
  localparam int SLOT_IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(FLOORS + 1);

  localparam logic [FLOOR_W-1:0] TOP_RESET = FLOOR_W'(10);

  typedef logic [FLOORS-1:0] map_t;

  typedef enum logic [1:0] {
    HEAD_IDLE = 2'd0,
    HEAD_UP   = 2'd1,
    HEAD_DOWN = 2'd2
  } heading_t;

  typedef enum logic [2:0] {
    ACT_IDLE      = 3'd0,
    ACT_MOVED     = 3'd1,
    ACT_STOPPED   = 3'd2,
    ACT_ACCEPTED  = 3'd3,
    ACT_BAD_FLOOR = 3'd4,
    ACT_FULL      = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_FREE = 2'd0,
    ST_WAIT = 2'd1,
    ST_RIDE = 2'd2
  } status_t;

  // Car controller to passenger table.
  typedef struct packed {
    logic               alloc;
    logic               stop;
    logic [FLOOR_W-1:0] floor;
    heading_t           heading;
  } ecc_cmd_t;

  // Passenger table to car controller.
  typedef struct packed {
    logic               free_found;
    logic [SLOT_IW-1:0] free_slot;
    logic [SLOTS-1:0]   boarded;
    logic [SLOTS-1:0]   done;
    map_t               up_set;
    map_t               dn_set;
  } ecc_stat_t;

  // One result beat.
  typedef struct packed {
    action_t      action;
    logic [2:0]   slot;
    logic [4:0]   floor;
    heading_t     heading;
    logic [7:0]   boarded_mask;
    logic [7:0]   completed_mask;
    logic [4:0]   up_calls;
    logic [4:0]   down_calls;
  } ecc_res_t;

endpackage

[sv/ecc_ptab.sv]
`timescale 1ns / 1ps

module ecc_ptab (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       fire,
  input  logic [ecc_pkg::FLOOR_W-1:0] from_floor,
  input  logic [ecc_pkg::FLOOR_W-1:0] to_floor,
  input  ecc_pkg::ecc_cmd_t          cmd,
  output ecc_pkg::ecc_stat_t         stat
);
  import ecc_pkg::*;

  status_t            st    [SLOTS];
  logic [FLOOR_W-1:0] pk_f  [SLOTS];
  logic [FLOOR_W-1:0] tg_f  [SLOTS];
  logic [SLOTS-1:0]   board;
  logic [SLOTS-1:0]   done;
  logic [SLOTS-1:0]   goes_up;

  always_comb begin
    stat = '0;
    board = '0;
    done = '0;
    goes_up = '0;
    // Downward scan so that the lowest free slot wins.
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (st[i] == ST_FREE) begin
        stat.free_found = 1'b1;
        stat.free_slot  = SLOT_IW'(i);
      end
    end
    for (int i = 0; i < SLOTS; i++) begin
      goes_up[i] = (tg_f[i] >= pk_f[i]);
      board[i] = cmd.stop && (st[i] == ST_WAIT) && (pk_f[i] == cmd.floor) &&
                 ((goes_up[i] && cmd.heading == HEAD_UP) ||
                  (!goes_up[i] && cmd.heading == HEAD_DOWN) ||
                  (cmd.heading == HEAD_IDLE));
      done[i] = cmd.stop && ((st[i] == ST_RIDE) || board[i]) && (tg_f[i] == cmd.floor);
      for (int f = 0; f < FLOORS; f++) begin
        if (board[i] && (tg_f[i] != cmd.floor) &&
            ({1'b0, tg_f[i]} == (FLOOR_W + 1)'(f + 1))) begin
          if (goes_up[i]) begin
            stat.up_set[f] = 1'b1;
          end else begin
            stat.dn_set[f] = 1'b1;
          end
        end
      end
    end
    stat.boarded = board;
    stat.done    = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        st[i] <= ST_FREE;
      end
    end else if (fire) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (cmd.alloc && stat.free_found && (stat.free_slot == SLOT_IW'(i))) begin
          st[i] <= ST_WAIT;
        end else if (done[i]) begin
          st[i] <= ST_FREE;
        end else if (board[i]) begin
          st[i] <= ST_RIDE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && cmd.alloc && stat.free_found) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (stat.free_slot == SLOT_IW'(i)) begin
          pk_f[i] <= from_floor;
          tg_f[i] <= to_floor;
        end
      end
    end
  end

endmodule

[sv/ecc_car.sv]
`timescale 1ns / 1ps

module ecc_car (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        fire,
  input  logic [ecc_pkg::FLOOR_W-1:0] top_floor,
  input  logic                        opcode,
  input  logic [ecc_pkg::FLOOR_W-1:0] from_floor,
  input  logic [ecc_pkg::FLOOR_W-1:0] to_floor,
  input  ecc_pkg::ecc_stat_t          stat,
  output ecc_pkg::ecc_cmd_t           cmd,
  output ecc_pkg::ecc_res_t           res
);
  import ecc_pkg::*;

  logic [FLOOR_W-1:0] car_floor;
  heading_t           car_heading;
  map_t               up_map;
  map_t               dn_map;

  logic [FLOOR_W-1:0] car_floor_next;
  heading_t           car_heading_next;
  map_t               up_map_next;
  map_t               dn_map_next;

  logic [FLOOR_W-1:0] top;
  map_t               all_map;
  map_t               above_m;
  map_t               below_m;
  map_t               here;
  map_t               pk_hot;
  logic               any_call;
  logic               above;
  logic               below;
  logic               cur_up;
  logic               cur_dn;
  logic               floors_ok;
  logic               stop;
  logic               clr_up;
  logic               clr_dn;
  heading_t           h1;
  heading_t           h2;
  heading_t           h3;
  logic [CNT_W-1:0]   up_cnt;
  logic [CNT_W-1:0]   dn_cnt;

  always_comb begin
    if ((FLOORS < 32) && (top_floor > FLOOR_W'(FLOORS))) begin
      top = FLOOR_W'(FLOORS);
    end else begin
      top = top_floor;
    end

    for (int i = 0; i < FLOORS; i++) begin
      above_m[i] = ((FLOOR_W + 1)'(i + 1) > {1'b0, car_floor});
      below_m[i] = ((FLOOR_W + 1)'(i + 1) < {1'b0, car_floor});
      here[i]    = ((FLOOR_W + 1)'(i + 1) == {1'b0, car_floor});
      pk_hot[i]  = ((FLOOR_W + 1)'(i + 1) == {1'b0, from_floor});
    end

    all_map  = up_map | dn_map;
    any_call = |all_map;
    above    = |(all_map & above_m);
    below    = |(all_map & below_m);
    cur_up   = |(up_map & here);
    cur_dn   = |(dn_map & here);

    floors_ok = (from_floor != '0) && (from_floor <= top) &&
                (to_floor != '0) && (to_floor <= top);

    // An idle car picks a direction before the stop decision.
    if (car_heading == HEAD_IDLE) begin
      h1 = above ? HEAD_UP : (below ? HEAD_DOWN : HEAD_IDLE);
    end else begin
      h1 = car_heading;
    end

    // LOOK stop: serve a call in the travelling direction, or turn round
    // at the last call in that direction.
    stop   = 1'b0;
    clr_up = 1'b0;
    clr_dn = 1'b0;
    h2     = h1;
    if (h1 == HEAD_UP || h1 == HEAD_IDLE) begin
      if (cur_up) begin
        stop = 1'b1;
        clr_up = 1'b1;
        h2 = HEAD_UP;
      end else if (!above && cur_dn) begin
        stop = 1'b1;
        clr_dn = 1'b1;
        h2 = HEAD_DOWN;
      end
    end
    if (!stop && (h1 == HEAD_DOWN || h1 == HEAD_IDLE)) begin
      if (cur_dn) begin
        stop = 1'b1;
        clr_dn = 1'b1;
        h2 = HEAD_DOWN;
      end else if (!below && cur_up) begin
        stop = 1'b1;
        clr_up = 1'b1;
        h2 = HEAD_UP;
      end
    end

    case (h1)
      HEAD_UP:   h3 = above ? HEAD_UP : (below ? HEAD_DOWN : HEAD_IDLE);
      HEAD_DOWN: h3 = below ? HEAD_DOWN : (above ? HEAD_UP : HEAD_IDLE);
      HEAD_IDLE: h3 = above ? HEAD_UP : (below ? HEAD_DOWN : HEAD_IDLE);
      default:   h3 = HEAD_IDLE;
    endcase

    cmd.alloc   = !opcode && floors_ok;
    cmd.stop    = opcode && any_call && stop;
    cmd.floor   = car_floor;
    cmd.heading = h2;

    car_floor_next   = car_floor;
    car_heading_next = car_heading;
    up_map_next      = up_map;
    dn_map_next      = dn_map;
    res              = '0;
    res.action       = ACT_IDLE;

    if (!opcode) begin
      if (!floors_ok) begin
        res.action = ACT_BAD_FLOOR;
      end else if (!stat.free_found) begin
        res.action = ACT_FULL;
      end else begin
        res.action = ACT_ACCEPTED;
        res.slot   = 3'(stat.free_slot);
        if (from_floor <= to_floor) begin
          up_map_next = up_map | pk_hot;
        end else begin
          dn_map_next = dn_map | pk_hot;
        end
      end
    end else if (any_call) begin
      if (stop) begin
        res.action       = ACT_STOPPED;
        car_heading_next = h2;
        up_map_next      = (up_map & ~(clr_up ? here : '0)) | stat.up_set;
        dn_map_next      = (dn_map & ~(clr_dn ? here : '0)) | stat.dn_set;
        res.boarded_mask   = 8'(stat.boarded);
        res.completed_mask = 8'(stat.done);
      end else begin
        car_heading_next = h3;
        if (h3 != HEAD_IDLE) begin
          res.action = ACT_MOVED;
          if (h3 == HEAD_UP && car_floor < top) begin
            car_floor_next = car_floor + FLOOR_W'(1);
          end else if (h3 == HEAD_DOWN && car_floor > FLOOR_W'(1)) begin
            car_floor_next = car_floor - FLOOR_W'(1);
          end
        end
      end
    end

    up_cnt = '0;
    dn_cnt = '0;
    for (int i = 0; i < FLOORS; i++) begin
      up_cnt = up_cnt + CNT_W'(up_map_next[i]);
      dn_cnt = dn_cnt + CNT_W'(dn_map_next[i]);
    end

    res.floor      = car_floor_next;
    res.heading    = car_heading_next;
    res.up_calls   = 5'(up_cnt);
    res.down_calls = 5'(dn_cnt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      car_floor   <= FLOOR_W'(1);
      car_heading <= HEAD_IDLE;
      up_map      <= '0;
      dn_map      <= '0;
    end else if (fire) begin
      car_floor   <= car_floor_next;
      car_heading <= car_heading_next;
      up_map      <= up_map_next;
      dn_map      <= dn_map_next;
    end
  end

endmodule

[sv/elevator_car_controller_top.sv]
`timescale 1ns / 1ps

// Elevator car controller: one car served by the LOOK rule. Each input beat is
// either a passenger request (opcode 0) or one tick of car operation
// (opcode 1), and gives exactly one result beat. A beat is held in an input
// register and worked through by combinational logic into the result
// register, so one beat is taken every clock cycle while the result side
// keeps up. While a result waits to be collected the input register takes at
// most one more beat, after which the input stalls. The highest served floor
// is written through the configuration channel (reset value 10) and should
// only be changed while no beat is in flight.
module elevator_car_controller_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       opcode,
  input  logic [4:0] from_floor,
  input  logic [4:0] to_floor,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] action,
  output logic [2:0] slot,
  output logic [4:0] floor,
  output logic [1:0] heading,
  output logic [7:0] boarded_mask,
  output logic [7:0] completed_mask,
  output logic [4:0] up_calls,
  output logic [4:0] down_calls
);
  import ecc_pkg::*;

  logic [FLOOR_W-1:0] top_floor;
  logic               s1_valid;
  logic               s1_opcode;
  logic [FLOOR_W-1:0] s1_pickup;
  logic [FLOOR_W-1:0] s1_target;
  logic               fire;
  ecc_cmd_t           cmd;
  ecc_stat_t          stat;
  ecc_res_t           res;
  ecc_res_t           res_q;

  assign cfg_ready = 1'b1;
  assign fire      = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_floor <= TOP_RESET;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        top_floor <= cfg_data;
      end
      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
      end else if (fire) begin
        s1_valid <= 1'b0;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_opcode <= opcode;
      s1_pickup <= from_floor;
      s1_target <= to_floor;
    end
    if (fire) begin
      res_q <= res;
    end
  end

  ecc_car u_car (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .top_floor    (top_floor),
    .opcode       (s1_opcode),
    .from_floor   (s1_pickup),
    .to_floor     (s1_target),
    .stat         (stat),
    .cmd          (cmd),
    .res          (res)
  );

  ecc_ptab u_ptab (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .from_floor   (s1_pickup),
    .to_floor     (s1_target),
    .cmd          (cmd),
    .stat         (stat)
  );

  assign action         = res_q.action;
  assign slot           = res_q.slot;
  assign floor          = res_q.floor;
  assign heading        = res_q.heading;
  assign boarded_mask   = res_q.boarded_mask;
  assign completed_mask = res_q.completed_mask;
  assign up_calls       = res_q.up_calls;
  assign down_calls     = res_q.down_calls;

endmodule

[dv/elevator_car_controller_top_tb.sv]
`timescale 1ns / 1ps

module elevator_car_controller_top_tb;
  import ecc_pkg::*;

  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_TICK    = 1'b1;
  localparam int   PHASE_ITEMS = 175;
  localparam int   LONG_HOLD   = 80;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [4:0] cfg_data = 5'd0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       opcode = OP_REQUEST;
  logic [4:0] from_floor = 5'd0;
  logic [4:0] to_floor = 5'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] action;
  logic [2:0] slot;
  logic [4:0] floor;
  logic [1:0] heading;
  logic [7:0] boarded_mask;
  logic [7:0] completed_mask;
  logic [4:0] up_calls;
  logic [4:0] down_calls;

  elevator_car_controller_top dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
    .from_floor(from_floor), .to_floor(to_floor),
    .out_valid(out_valid), .out_ready(out_ready),
    .action(action), .slot(slot), .floor(floor), .heading(heading),
    .boarded_mask(boarded_mask), .completed_mask(completed_mask),
    .up_calls(up_calls), .down_calls(down_calls)
  );

  always #5 clk = ~clk;

  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

  // Car state as the testbench sees it.
  logic [4:0] top_cfg = TOP_RESET;
  logic [4:0] car_pos = 5'd1;
  heading_t   car_dir = HEAD_IDLE;
  map_t       up_map = '0;
  map_t       dn_map = '0;
  status_t    rider_st [SLOTS];
  logic [4:0] rider_pk [SLOTS];
  logic [4:0] rider_tg [SLOTS];

  ecc_res_t due_results [$];

  typedef struct {
    logic       op;
    logic [4:0] pk;
    logic [4:0] tg;
    logic       known;
    ecc_res_t   res;
  } dir_row_t;

  dir_row_t dir_rows [$];

  logic [4:0] top_plan [8] = '{5'd16, 5'd2, 5'd31, 5'd0, 5'd7, 5'd1, 5'd16, 5'd3};

  int send_idle_pct = 21;
  int recv_idle_pct = 51;
  bit long_hold_due = 1'b0;
  int hold_left = 0;
  int mismatches = 0;
  int items_sent = 0;
  int results_checked = 0;
  int stop_count = 0;
  int full_count = 0;
  int bad_count = 0;

  function automatic logic [4:0] served_top();
    return (top_cfg > FLOORS) ? 5'(FLOORS) : top_cfg;
  endfunction

  function automatic map_t floor_mask(input logic [4:0] f);
    return map_t'(1) << (f - 5'd1);
  endfunction

  function automatic logic calls_above();
    return ((up_map | dn_map) >> car_pos) != '0;
  endfunction

  function automatic logic calls_below();
    return ((up_map | dn_map) & (floor_mask(car_pos) - map_t'(1))) != '0;
  endfunction

  // Direction review; returns 1 when the car is left idle.
  function automatic logic settle_heading();
    logic above, below;
    if ((up_map | dn_map) == '0) begin
      car_dir = HEAD_IDLE;
      return 1'b1;
    end
    above = calls_above();
    below = calls_below();
    case (car_dir)
      HEAD_UP: begin
        if (above) return 1'b0;
        car_dir = below ? HEAD_DOWN : HEAD_IDLE;
      end
      HEAD_DOWN: begin
        if (below) return 1'b0;
        car_dir = above ? HEAD_UP : HEAD_IDLE;
      end
      default: begin
        if (above) car_dir = HEAD_UP;
        else if (below) car_dir = HEAD_DOWN;
      end
    endcase
    return car_dir == HEAD_IDLE;
  endfunction

  // LOOK rule: a call in the travel direction is served first; the opposite
  // call at this floor only when nothing lies further on.
  function automatic logic look_stop();
    map_t here;
    logic above, below;
    here  = floor_mask(car_pos);
    above = calls_above();
    below = calls_below();
    if (car_dir == HEAD_UP || car_dir == HEAD_IDLE) begin
      if ((up_map & here) != '0) begin
        up_map &= ~here;
        car_dir = HEAD_UP;
        return 1'b1;
      end
      if (!above && (dn_map & here) != '0) begin
        dn_map &= ~here;
        car_dir = HEAD_DOWN;
        return 1'b1;
      end
    end
    if (car_dir == HEAD_DOWN || car_dir == HEAD_IDLE) begin
      if ((dn_map & here) != '0) begin
        dn_map &= ~here;
        car_dir = HEAD_DOWN;
        return 1'b1;
      end
      if (!below && (up_map & here) != '0) begin
        up_map &= ~here;
        car_dir = HEAD_UP;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void serve_floor(output logic [7:0] boarded, output logic [7:0] arrived);
    logic rising;
    boarded = '0;
    arrived = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (rider_st[i] == ST_WAIT && rider_pk[i] == car_pos) begin
        rising = rider_tg[i] >= rider_pk[i];
        if ((rising && car_dir == HEAD_UP) || (!rising && car_dir == HEAD_DOWN) ||
            car_dir == HEAD_IDLE) begin
          rider_st[i] = ST_RIDE;
          boarded[i] = 1'b1;
          if (rider_tg[i] != car_pos) begin
            if (rising) up_map |= floor_mask(rider_tg[i]);
            else dn_map |= floor_mask(rider_tg[i]);
          end
        end
      end
      // A passenger boarding at its own target floor leaves straight away.
      if (rider_st[i] == ST_RIDE && rider_tg[i] == car_pos) begin
        rider_st[i] = ST_FREE;
        arrived[i] = 1'b1;
      end
    end
  endfunction

  function automatic ecc_res_t car_step(input logic op, input logic [4:0] pk,
                                        input logic [4:0] tg);
    ecc_res_t   r;
    logic [4:0] top;
    logic [7:0] brd, dne;
    r   = '0;
    brd = '0;
    dne = '0;
    top = served_top();
    r.action = ACT_IDLE;
    if (op == OP_REQUEST) begin
      if (pk < 5'd1 || pk > top || tg < 5'd1 || tg > top) begin
        r.action = ACT_BAD_FLOOR;
      end else begin
        r.action = ACT_FULL;
        for (int i = 0; i < SLOTS; i++) begin
          if (rider_st[i] == ST_FREE) begin
            rider_st[i] = ST_WAIT;
            rider_pk[i] = pk;
            rider_tg[i] = tg;
            if (pk <= tg) up_map |= floor_mask(pk);
            else dn_map |= floor_mask(pk);
            r.action = ACT_ACCEPTED;
            r.slot = 3'(i);
            break;
          end
        end
      end
    end else if ((up_map | dn_map) != '0) begin
      if (car_dir == HEAD_IDLE) void'(settle_heading());
      if (look_stop()) begin
        serve_floor(brd, dne);
        r.action = ACT_STOPPED;
      end else if (settle_heading()) begin
        r.action = ACT_IDLE;
      end else begin
        if (car_dir == HEAD_UP && car_pos < top) car_pos = car_pos + 5'd1;
        else if (car_dir == HEAD_DOWN && car_pos > 5'd1) car_pos = car_pos - 5'd1;
        r.action = ACT_MOVED;
      end
    end
    r.floor          = car_pos;
    r.heading        = car_dir;
    r.boarded_mask   = brd;
    r.completed_mask = dne;
    r.up_calls       = 5'($countones(up_map));
    r.down_calls     = 5'($countones(dn_map));
    return r;
  endfunction

  task automatic known_row(input logic op, input logic [4:0] pk, input logic [4:0] tg,
                           input action_t a, input logic [2:0] sl, input logic [4:0] fl,
                           input heading_t hd, input logic [4:0] upc, input logic [4:0] dnc);
    dir_row_t row;
    row.op = op;
    row.pk = pk;
    row.tg = tg;
    row.known = 1'b1;
    row.res = '0;
    row.res.action = a;
    row.res.slot = sl;
    row.res.floor = fl;
    row.res.heading = hd;
    row.res.up_calls = upc;
    row.res.down_calls = dnc;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  task automatic open_row(input logic op, input logic [4:0] pk, input logic [4:0] tg);
    dir_row_t row;
    row.op = op;
    row.pk = pk;
    row.tg = tg;
    row.known = 1'b0;
    row.res = '0;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  task automatic offer_item(input logic op, input logic [4:0] pk, input logic [4:0] tg,
                            input logic known, input ecc_res_t fixed);
    ecc_res_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    from_floor <= pk;
    to_floor <= tg;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = car_step(op, pk, tg);
    if (known) pred = fixed;
    due_results.insert(due_results.size(), pred);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_top(input logic [4:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    top_cfg = v;
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (long_hold_due) begin
      long_hold_due = 1'b0;
      hold_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    ecc_res_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, action %0d", $time, action);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        check_field("action", 8'(want.action), 8'(action));
        check_field("slot", 8'(want.slot), 8'(slot));
        check_field("floor", 8'(want.floor), 8'(floor));
        check_field("heading", 8'(want.heading), 8'(heading));
        check_field("boarded_mask", want.boarded_mask, boarded_mask);
        check_field("completed_mask", want.completed_mask, completed_mask);
        check_field("up_calls", 8'(want.up_calls), 8'(up_calls));
        check_field("down_calls", 8'(want.down_calls), 8'(down_calls));
        results_checked++;
        if (want.action == ACT_STOPPED) stop_count++;
        if (want.action == ACT_FULL) full_count++;
        if (want.action == ACT_BAD_FLOOR) bad_count++;
      end
    end
  end

  initial begin
    int unsigned roll;
    logic        op;
    logic [4:0]  top_now, pk, tg;

    for (int i = 0; i < SLOTS; i++) begin
      rider_st[i] = ST_FREE;
      rider_pk[i] = 5'd0;
      rider_tg[i] = 5'd0;
    end

    // Reset top is 10: no calls yet, then floors outside the range, then three accepted requests.
    known_row(OP_TICK, 5'd0, 5'd0, ACT_IDLE, 3'd0, 5'd1, HEAD_IDLE, 5'd0, 5'd0);
    known_row(OP_REQUEST, 5'd0, 5'd5, ACT_BAD_FLOOR, 3'd0, 5'd1, HEAD_IDLE, 5'd0, 5'd0);
    known_row(OP_REQUEST, 5'd3, 5'd11, ACT_BAD_FLOOR, 3'd0, 5'd1, HEAD_IDLE, 5'd0, 5'd0);
    known_row(OP_REQUEST, 5'd31, 5'd31, ACT_BAD_FLOOR, 3'd0, 5'd1, HEAD_IDLE, 5'd0, 5'd0);
    known_row(OP_REQUEST, 5'd10, 5'd0, ACT_BAD_FLOOR, 3'd0, 5'd1, HEAD_IDLE, 5'd0, 5'd0);
    known_row(OP_REQUEST, 5'd10, 5'd1, ACT_ACCEPTED, 3'd0, 5'd1, HEAD_IDLE, 5'd0, 5'd1);
    known_row(OP_REQUEST, 5'd1, 5'd10, ACT_ACCEPTED, 3'd1, 5'd1, HEAD_IDLE, 5'd1, 5'd1);
    known_row(OP_REQUEST, 5'd1, 5'd1, ACT_ACCEPTED, 3'd2, 5'd1, HEAD_IDLE, 5'd1, 5'd1);
    // First stop boards two and completes the same-floor passenger at once.
    open_row(OP_TICK, 5'd31, 5'd31);
    for (int i = 0; i < 10; i++) open_row(OP_TICK, 5'(i), 5'(31 - i));
    // Fill the remaining slots, then one request too many.
    open_row(OP_REQUEST, 5'd2, 5'd9);
    open_row(OP_REQUEST, 5'd3, 5'd8);
    open_row(OP_REQUEST, 5'd4, 5'd7);
    open_row(OP_REQUEST, 5'd5, 5'd6);
    open_row(OP_REQUEST, 5'd6, 5'd5);
    open_row(OP_REQUEST, 5'd9, 5'd2);
    open_row(OP_REQUEST, 5'd7, 5'd4);
    open_row(OP_REQUEST, 5'd8, 5'd8);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      offer_item(dir_rows[i].op, dir_rows[i].pk, dir_rows[i].tg, dir_rows[i].known,
                 dir_rows[i].res);

    for (int ph = 0; ph < 8; ph++) begin
      send_idle_pct = (ph < 3) ? 21 : (ph < 6) ? 51 : 0;
      recv_idle_pct = (ph < 3) ? 51 : (ph < 6) ? 21 : 0;
      set_top(top_plan[ph]);
      if (ph == 1 || ph == 6) long_hold_due = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll    = $urandom_range(99);
        top_now = served_top();
        pk      = 5'($urandom_range(31));
        tg      = 5'($urandom_range(31));
        if (roll < 58) begin
          op = OP_TICK;
        end else begin
          op = OP_REQUEST;
          // Mostly floors in range; the rest are left as raw five-bit values.
          if (roll < 92 && top_now != 5'd0) begin
            pk = 5'($urandom_range(top_now, 1));
            tg = 5'($urandom_range(top_now, 1));
          end
        end
        offer_item(op, pk, tg, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (4) @(posedge clk);

    $display("tb: %0d beats under %0d top-floor settings, %0d results compared",
             items_sent, 8, results_checked);
    $display("tb: %0d stops, %0d full-table and %0d bad-floor answers seen",
             stop_count, full_count, bad_count);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sim.f]
sv/ecc_pkg.sv
sv/ecc_ptab.sv
sv/ecc_car.sv
sv/elevator_car_controller_top.sv
dv/elevator_car_controller_top_tb.sv
